// ===== design/sbar_pkg.sv =====
// shared types, constants and palette function for the screen byte attribute renderer
package sbar_pkg;

   localparam int unsigned PIXEL_COUNT = 8;
   localparam int unsigned CNT_WIDTH   = $clog2(PIXEL_COUNT);

   localparam logic [7:0] LEVEL_NORMAL = 8'd192;
   localparam logic [7:0] LEVEL_BRIGHT = 8'd255;

   typedef struct packed {
      logic [7:0] pixel_bits;
      logic [3:0] ink;
      logic [3:0] paper;
      logic [4:0] column;
      logic [7:0] pixel_y;
   } decoded_type;

   typedef struct packed {
      logic       is_ink;
      logic [3:0] ink;
      logic [3:0] paper;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic       last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // blue is index bit 0, red bit 1, green bit 2, bit 3 picks the bright level
   function automatic rgb_type palette_lookup(input logic [3:0] index);
      logic [7:0] level;
      rgb_type    rgb;
      level     = index[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
      rgb.red   = index[1] ? level : 8'd0;
      rgb.green = index[2] ? level : 8'd0;
      rgb.blue  = index[0] ? level : 8'd0;
      return rgb;
   endfunction

endpackage

// ===== design/screen_byte_attribute_renderer_core.sv =====
// Screen byte attribute renderer, top level.
//
// A request transaction carries one bitmap byte, its attribute byte and the
// byte's offset in the interleaved bitmap. The block answers with eight
// response transactions, leftmost pixel first, each with screen column and
// row, palette index, RGB and a last_pixel flag on the eighth.
// A request passes the decode, serializer, index and output registers in that
// order; the remaining seven pixels of the byte follow, left to right.
// Throughput: one pixel per cycle while rsp_stall is low, set by
// the serializer that walks the byte. The next byte is taken while the
// current one is still being shifted out, so bytes stream without gaps.
// flash_phase is written over the csr channel, which is always ready; it
// resets to 1 and is sampled when a request is taken.
// Reset empties every stage. When rsp_stall is high the output holds and the
// stages behind it fill, then req_stall rises; nothing is dropped or repeated.
module screen_byte_attribute_renderer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel_byte,
   input  logic [7:0]  req_attribute,
   input  logic [12:0] req_byte_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [3:0]  rsp_colour_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_flash_phase
);
   import sbar_pkg::*;

   logic        flash_phase_ff;
   logic        dec_valid, dec_take;
   decoded_type dec_data;
   logic        pix_valid, pix_take;
   pixel_type   pix_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_phase_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         flash_phase_ff <= csr_flash_phase;
      end
   end

   sbar_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_byte  (req_pixel_byte),
      .req_attribute   (req_attribute),
      .req_byte_offset (req_byte_offset),
      .flash_phase     (flash_phase_ff),
      .dec_valid       (dec_valid),
      .dec_take        (dec_take),
      .dec_data        (dec_data)
   );

   sbar_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .dec_valid (dec_valid),
      .dec_take  (dec_take),
      .dec_data  (dec_data),
      .pix_valid (pix_valid),
      .pix_take  (pix_take),
      .pix_data  (pix_data)
   );

   sbar_colour u_colour (
      .clock            (clock),
      .reset            (reset),
      .pix_valid        (pix_valid),
      .pix_take         (pix_take),
      .pix_data         (pix_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_colour_index (rsp_colour_index),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last_pixel   (rsp_last_pixel)
   );

`ifndef ASSERT_OFF
   // last flag only on the rightmost pixel of a byte
   a_last_on_pixel7: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_pixel == (rsp_pixel_x[2:0] == 3'h7)))
      else $error("last_pixel does not match pixel position");

   // red channel follows index bit 1
   a_red_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_red != 8'd0) == rsp_colour_index[1]))
      else $error("red component does not match colour index");

   // pixels of one byte come in order: after a non-last pixel leaves, the next is its neighbor
   a_pixel_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_pixel) ##1 rsp_valid
      |-> (rsp_pixel_x == $past(rsp_pixel_x) + 8'd1) && (rsp_pixel_y == $past(rsp_pixel_y)))
      else $error("pixel sequence within a byte broken");

   // nothing comes out right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

// ===== design/sbar_decode.sv =====
// input register stage: attribute decode, flash swap and row address unscramble
module sbar_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_pixel_byte,
   input  logic [7:0]           req_attribute,
   input  logic [12:0]          req_byte_offset,
   input  logic                 flash_phase,
   output logic                 dec_valid,
   input  logic                 dec_take,
   output sbar_pkg::decoded_type dec_data
);
   import sbar_pkg::*;

   logic        valid_ff, valid_in;
   decoded_type data_ff, data_in;
   logic        swap;
   logic [3:0]  ink, paper;
   logic        load;

   assign req_stall = valid_ff && !dec_take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      ink   = {req_attribute[6], req_attribute[2:0]};
      paper = {req_attribute[6], req_attribute[5:3]};
      swap  = req_attribute[7] && !flash_phase;
      data_in.pixel_bits = req_pixel_byte;
      data_in.ink        = swap ? paper : ink;
      data_in.paper      = swap ? ink : paper;
      data_in.column     = req_byte_offset[4:0];
      // zone, character row, line within the character
      data_in.pixel_y    = {req_byte_offset[12:11], req_byte_offset[7:5],
                            req_byte_offset[10:8]};
      valid_in = load || (valid_ff && !dec_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign dec_valid = valid_ff;
   assign dec_data  = data_ff;

endmodule

// ===== design/sbar_serializer.sv =====
// byte to pixel serializer: one pixel per cycle while pix_take is high, leftmost first
module sbar_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  dec_valid,
   output logic                  dec_take,
   input  sbar_pkg::decoded_type dec_data,
   output logic                  pix_valid,
   input  logic                  pix_take,
   output sbar_pkg::pixel_type   pix_data
);
   import sbar_pkg::*;

   logic                 valid_ff, valid_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   decoded_type          data_ff, data_in;
   logic                 last;
   logic                 emit;

   assign last     = (count_ff == CNT_WIDTH'(PIXEL_COUNT - 1));
   assign emit     = valid_ff && pix_take;
   assign dec_take = !valid_ff || (emit && last);

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      data_in  = data_ff;
      if (dec_take) begin
         valid_in = dec_valid;
         count_in = '0;
         data_in  = dec_data;
      end else if (emit) begin
         count_in = count_ff + 1'b1;
         data_in.pixel_bits = {data_ff.pixel_bits[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      data_ff <= data_in;
   end

   always_comb begin
      pix_data.is_ink     = data_ff.pixel_bits[7];
      pix_data.ink        = data_ff.ink;
      pix_data.paper      = data_ff.paper;
      pix_data.pixel_x    = {data_ff.column, count_ff};
      pix_data.pixel_y    = data_ff.pixel_y;
      pix_data.last_pixel = last;
   end

   assign pix_valid = valid_ff;

endmodule

// ===== design/sbar_colour.sv =====
// colour stages: index select, then palette lookup into the output register
module sbar_colour (
   input  logic                clock,
   input  logic                reset,
   input  logic                pix_valid,
   output logic                pix_take,
   input  sbar_pkg::pixel_type pix_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_pixel_x,
   output logic [7:0]          rsp_pixel_y,
   output logic [3:0]          rsp_colour_index,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic                rsp_last_pixel
);
   import sbar_pkg::*;

   logic       idx_valid_ff, idx_valid_in;
   logic [3:0] idx_ff;
   logic [7:0] idx_x_ff, idx_y_ff;
   logic       idx_last_ff;
   logic       idx_take;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_x_ff, out_y_ff;
   logic [3:0] out_idx_ff;
   rgb_type    out_rgb_ff;
   logic       out_last_ff;
   logic       out_open;

   assign out_open = !out_valid_ff || !rsp_stall;
   assign idx_take = idx_valid_ff && out_open;
   assign pix_take = !idx_valid_ff || out_open;

   assign idx_valid_in = pix_take ? pix_valid : idx_valid_ff;
   assign out_valid_in = out_open ? idx_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_valid_ff <= idx_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (pix_take && pix_valid) begin
         idx_ff      <= pix_data.is_ink ? pix_data.ink : pix_data.paper;
         idx_x_ff    <= pix_data.pixel_x;
         idx_y_ff    <= pix_data.pixel_y;
         idx_last_ff <= pix_data.last_pixel;
      end
      if (idx_take) begin
         out_idx_ff  <= idx_ff;
         out_rgb_ff  <= palette_lookup(idx_ff);
         out_x_ff    <= idx_x_ff;
         out_y_ff    <= idx_y_ff;
         out_last_ff <= idx_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_x      = out_x_ff;
   assign rsp_pixel_y      = out_y_ff;
   assign rsp_colour_index = out_idx_ff;
   assign rsp_red          = out_rgb_ff.red;
   assign rsp_green        = out_rgb_ff.green;
   assign rsp_blue         = out_rgb_ff.blue;
   assign rsp_last_pixel   = out_last_ff;

endmodule
